// ----- hdl/dtq_pkg.sv -----
// dtq_pkg: shared types and codes for the deadline timer queue
// no dependencies
package dtq_pkg;
  localparam int IdW = 64;
  localparam int DueW = 48;
  localparam int CtxW = 32;
  localparam int OrdW = 32;
  localparam int ResultCap = 16;

  localparam logic [1:0] OpSched = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;
  localparam logic [1:0] OpIgnore = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBusy = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  // entry travelling along the cell chain
  typedef struct packed {
    logic            vld;
    logic [IdW-1:0]  id;
    logic [DueW-1:0] due;
    logic [OrdW-1:0] ord;
    logic [CtxW-1:0] ctx;
  } entry_t;

  // chain control: shift reaches every cell, the rest shapes the entry fed to cell 0
  typedef struct packed {
    logic            shift;   // rotate chain by one cell
    logic            clr_tail; // invalidate the entry leaving the last cell
    logic            wr_tail; // write new entry into cell 0 in place of the one leaving the last cell
    entry_t          wdata;
  } cell_ctl_t;
endpackage

// ----- hdl/dtq_cell.sv -----
// dtq_cell: one storage cell of the rotating entry chain
// depends on dtq_pkg
module dtq_cell import dtq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t prev_i,
  output entry_t entry_o
);
  entry_t ent_q;
  logic   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= prev_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= prev_i;
    end
  end

  always_comb begin
    entry_o = ent_q;
    entry_o.vld = vld_q;
  end
endmodule

// ----- hdl/deadline_timer_queue_core.sv -----
// deadline_timer_queue_core: deadline store built as a rotating chain of cells
// depends on dtq_pkg, dtq_cell
//
// channel  direction  signals
// in       sink       in_valid_i / in_ready_o, operation_i .. now_time_i
// out      source     out_valid_o / out_ready_i, status_o .. last_result_o
//
// cancel: result after one full rotation of the chain once the request is taken
// schedule: one rotation, then a search for a free cell when a new entry needs one
// tick: first result after a find pass plus a take pass, each further one after
// another take pass once the previous is taken; nothing due: after the find pass
// ignored operation: result in the cycle after the request; one request at a time
// reset clears all valid bits and the order counter; a stalled result holds all
module deadline_timer_queue_core import dtq_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int MAX_PER_TICK = 16,
  parameter int TIME_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [IdW-1:0]  timer_id_i,
  input  logic [DueW-1:0] due_time_i,
  input  logic [CtxW-1:0] context_word_i,
  input  logic [DueW-1:0] now_time_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic            expired_valid_o,
  output logic [IdW-1:0]  expired_timer_id_o,
  output logic [CtxW-1:0] expired_context_o,
  output logic            last_result_o
);
  localparam int CntW = $clog2(SLOTS);
  localparam int Limit = (MAX_PER_TICK < ResultCap) ? MAX_PER_TICK : ResultCap;
  localparam int LimW = $clog2(Limit + 1);
  localparam logic [DueW-1:0] TimeMask = DueW'({TIME_BITS{1'b1}});

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_INS  = 6'b000100,
    S_FIND = 6'b001000,
    S_TAKE = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  entry_t chain [SLOTS];
  entry_t head;
  entry_t feed;
  entry_t new_ent;
  cell_ctl_t ctl;

  logic [1:0]      op_q;
  logic [IdW-1:0]  id_q;
  logic [DueW-1:0] due_q, now_q;
  logic [CtxW-1:0] ctx_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [OrdW-1:0] next_ord_q;
  logic            hit_q, free_q;
  logic            cand_vld_q, cand_vld_d;
  logic [DueW-1:0] cand_due_q, cand_due_d;
  logic [OrdW-1:0] cand_ord_q, cand_ord_d;
  logic [IdW-1:0]  cand_id_q, cand_id_d;
  logic [CtxW-1:0] cand_ctx_q, cand_ctx_d;
  logic [DueW-1:0] tgt_due_q;
  logic [OrdW-1:0] tgt_ord_q;
  logic [IdW-1:0]  tgt_id_q;
  logic [CtxW-1:0] tgt_ctx_q;
  logic [LimW-1:0] emit_q;
  logic [1:0]      st_q;
  logic            ev_q, last_q;
  logic [IdW-1:0]  eid_q;
  logic [CtxW-1:0] ectx_q;

  logic id_match, due_ok, is_tgt, take_head, last_cyc;
  logic ord_free, hit_any, free_any;

  assign head = chain[SLOTS-1];

  // entry arriving at cell 0 is the one leaving the last cell, possibly modified
  always_comb begin
    feed = head;
    if (ctl.clr_tail) feed.vld = 1'b0;
    if (ctl.wr_tail)  feed = ctl.wdata;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dtq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctl.shift),
      .prev_i  (g == 0 ? feed : chain[(g == 0) ? 0 : g-1]),
      .entry_o (chain[g])
    );
  end

  assign ord_free = next_ord_q != '1;
  assign id_match = head.vld && head.id == id_q;
  assign due_ok = head.vld && head.due <= now_q;
  assign is_tgt = head.vld && head.due == tgt_due_q && head.ord == tgt_ord_q;
  assign last_cyc = cnt_q == CntW'(SLOTS - 1);
  assign hit_any = hit_q || id_match;
  assign free_any = free_q || !head.vld;

  // earliest due entry seen so far in this pass, skipping the one being taken
  assign take_head = due_ok && !(state_q == S_TAKE && is_tgt) &&
                     (!cand_vld_q || head.due < cand_due_q ||
                      (head.due == cand_due_q && head.ord < cand_ord_q));

  always_comb begin
    cand_vld_d = cand_vld_q;
    cand_due_d = cand_due_q;
    cand_ord_d = cand_ord_q;
    cand_id_d  = cand_id_q;
    cand_ctx_d = cand_ctx_q;
    if (take_head) begin
      cand_vld_d = 1'b1;
      cand_due_d = head.due;
      cand_ord_d = head.ord;
      cand_id_d  = head.id;
      cand_ctx_d = head.ctx;
    end
  end

  always_comb begin
    new_ent.vld = 1'b1;
    new_ent.id  = id_q;
    new_ent.due = due_q;
    new_ent.ord = next_ord_q;
    new_ent.ctx = ctx_q;
  end

  // slot position is never visible outside, so any free cell takes a new entry
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ctl = '0;
    ctl.wdata = new_ent;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          unique case (operation_i)
            OpTick: state_d = S_FIND;
            OpSched, OpCancel: state_d = S_SCAN;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        ctl.shift = 1'b1;
        if (op_q == OpCancel && id_match) ctl.clr_tail = 1'b1;
        if (op_q == OpSched && ord_free && id_match) ctl.wr_tail = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_cyc) begin
          cnt_d = '0;
          state_d = (op_q == OpSched && ord_free && !hit_any && free_any) ? S_INS : S_OUT;
        end
      end
      S_INS: begin
        ctl.shift = 1'b1;
        if (!head.vld) begin
          ctl.wr_tail = 1'b1;
          state_d = S_OUT;
        end
      end
      S_FIND: begin
        ctl.shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_cyc) begin
          cnt_d = '0;
          state_d = cand_vld_d ? S_TAKE : S_OUT;
        end
      end
      S_TAKE: begin
        ctl.shift = 1'b1;
        if (is_tgt) ctl.clr_tail = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (last_cyc) begin
          cnt_d = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          cnt_d = '0;
          state_d = (op_q == OpTick && !last_q) ? S_TAKE : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      next_ord_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      cand_vld_q <= 1'b0;
      emit_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      unique case (state_q)
        S_IDLE: begin
          hit_q <= 1'b0;
          free_q <= 1'b0;
          cand_vld_q <= 1'b0;
          emit_q <= '0;
        end
        S_SCAN: begin
          if (id_match) hit_q <= 1'b1;
          if (!head.vld) free_q <= 1'b1;
          if (last_cyc && op_q == OpSched && ord_free && hit_any)
            next_ord_q <= next_ord_q + 1'b1;
        end
        S_INS: begin
          if (!head.vld) next_ord_q <= next_ord_q + 1'b1;
        end
        S_FIND, S_TAKE: begin
          cand_vld_q <= last_cyc ? 1'b0 : cand_vld_d;
          if (last_cyc && state_q == S_TAKE) emit_q <= emit_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= operation_i;
      id_q <= timer_id_i;
      due_q <= due_time_i & TimeMask;
      ctx_q <= context_word_i;
      now_q <= now_time_i & TimeMask;
    end
    if (state_q == S_FIND || state_q == S_TAKE) begin
      cand_due_q <= cand_due_d;
      cand_ord_q <= cand_ord_d;
      cand_id_q <= cand_id_d;
      cand_ctx_q <= cand_ctx_d;
      // the best entry of this pass is the one taken by the next pass
      if (last_cyc) begin
        tgt_due_q <= cand_due_d;
        tgt_ord_q <= cand_ord_d;
        tgt_id_q <= cand_id_d;
        tgt_ctx_q <= cand_ctx_d;
      end
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_q <= StOk;
          ev_q <= 1'b0;
          last_q <= 1'b1;
        end
      end
      S_SCAN: begin
        if (last_cyc) begin
          if (op_q == OpCancel) st_q <= hit_any ? StOk : StNotFound;
          else if (!ord_free) st_q <= StBusy;
          else st_q <= (hit_any || free_any) ? StOk : StBusy;
        end
      end
      S_TAKE: begin
        if (last_cyc) begin
          st_q <= StOk;
          ev_q <= 1'b1;
          eid_q <= tgt_id_q;
          ectx_q <= tgt_ctx_q;
          last_q <= !cand_vld_d || (emit_q + 1'b1) == LimW'(Limit);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = state_q == S_OUT;
  assign status_o = st_q;
  assign expired_valid_o = ev_q;
  assign expired_timer_id_o = ev_q ? eid_q : '0;
  assign expired_context_o = ev_q ? ectx_q : '0;
  assign last_result_o = last_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_emit_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= LimW'(Limit)) else $error("too many expiries");
`endif
endmodule
